/* hdl/vgh_pkg.sv */
`timescale 1ns / 1ps

package vgh_pkg;

    // Histogram geometry and count precision.
    localparam int COUNT_WIDTH       = 24;
    localparam int LOG_FRACTION_BITS = 8;
    localparam int BIN_COUNT         = 65536;
    localparam int BIN_ADDR_W        = $clog2(BIN_COUNT);
    localparam int BYTE_W            = 8;
    localparam int SCALE_W           = 8;

    // Fixed-point log2: exponent bits, then fraction bits.
    localparam int EXP_W   = $clog2(COUNT_WIDTH);
    localparam int LOG_W   = EXP_W + LOG_FRACTION_BITS;
    localparam int ROUND_W = $clog2(LOG_FRACTION_BITS);
    localparam int SQ_W    = 32;

    // Divider operand widths: the numerator is 255 times the wider operand.
    localparam int DEN_W   = (COUNT_WIDTH > LOG_W) ? COUNT_WIDTH : LOG_W;
    localparam int NUM_W   = DEN_W + SCALE_W;
    localparam int STEP_W  = $clog2(NUM_W);

    // Item modes.
    localparam logic [1:0] MODE_ACCUMULATE = 2'd0;
    localparam logic [1:0] MODE_READ       = 2'd1;
    localparam logic [1:0] MODE_CLEAR      = 2'd2;

    // Histogram kinds.
    localparam logic KIND_JOINT = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_HISTOGRAM_KIND = 1'b0;

    typedef struct packed {
        logic [1:0]            mode;
        logic [BYTE_W-1:0]     voxel_value;
        logic [BYTE_W-1:0]     gradient_value;
        logic [BIN_ADDR_W-1:0] bin_index;
    } in_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] bin_count;
        logic [SCALE_W-1:0]     scaled_value;
    } out_t;

    typedef struct packed {
        logic item_load;
        logic clr_start;
        logic clr_wr;
        logic mem_rd;
        logic acc_wr;
        logic cnt_load;
        logic log_start;
        logic log_sel_max;
        logic lm_load;
        logic div_start;
        logic div_sel_log;
        logic scale_zero;
        logic scale_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic max_zero;
        logic max_le1;
        logic lm_zero;
        logic log_done;
        logic div_done;
        logic clr_last;
        logic out_free;
    } status_t;

endpackage

/* hdl/value_gradient_histogram_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  vgh_pkg::in_t  (mode, voxel, gradient, bin)
// m_        out        m_valid / m_ready  vgh_pkg::out_t (bin count, scaled byte)
// APB       in         psel/penable/pready  histogram_kind at byte address 0
//
// One item is worked at a time by the controller. An accumulate reads its
// bin, then writes back the incremented count. A value-only read runs the
// bit-serial divider; a joint read adds two log2 passes
// through the shared log unit. A clear writes one bin per cycle after its
// transaction, and the same sweep runs after reset before the first item is
// taken. A read waits in its final state while the previous result has not
// been taken.

module value_gradient_histogram_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  vgh_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output vgh_pkg::out_t  m_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic              kind_reg, kind_next;
    logic              cfg_wr;
    vgh_pkg::cmd_t     cmd;
    vgh_pkg::status_t  status;

    // Configuration register write on the access phase of a transaction.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[2] == vgh_pkg::REG_HISTOGRAM_KIND);
    assign kind_next = cfg_wr ? pwdata[0] : kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= vgh_pkg::KIND_JOINT;
        end else begin
            kind_reg <= kind_next;
        end
    end

    assign prdata = (paddr[2] == vgh_pkg::REG_HISTOGRAM_KIND) ? {31'b0, kind_reg} : '0;

    vgh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_data.mode),
        .kind    (kind_reg),
        .status  (status),
        .cmd     (cmd)
    );

    vgh_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .kind    (kind_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* hdl/vgh_log_unit.sv */
`timescale 1ns / 1ps

module vgh_log_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [vgh_pkg::COUNT_WIDTH-1:0] x,
    output logic                     done,
    output logic [vgh_pkg::LOG_W-1:0] result
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQ   = 2'd2;

    localparam int CW = vgh_pkg::COUNT_WIDTH;
    localparam int FB = vgh_pkg::LOG_FRACTION_BITS;

    logic [1:0]                     state_reg, state_next;
    logic                           done_reg, done_next;
    logic [CW-1:0]                  x_reg, x_next;
    logic [vgh_pkg::EXP_W-1:0]      e_reg, e_next;
    logic [vgh_pkg::SQ_W-1:0]       y_reg, y_next;
    logic [FB-1:0]                  frac_reg, frac_next;
    logic [vgh_pkg::ROUND_W-1:0]    k_reg, k_next;
    logic [CW-1+FB-1:0]             below_lead;
    logic [FB-1:0]                  mant;
    logic [2*vgh_pkg::SQ_W-1:0]     prod;
    logic [vgh_pkg::SQ_W:0]         sq;

    // Bits below the leading one, zero-filled when the value is short.
    assign below_lead = {x_reg[CW-2:0], {FB{1'b0}}};
    assign mant       = below_lead[CW-2+FB -: FB];
    assign prod       = (2*vgh_pkg::SQ_W)'(y_reg) * (2*vgh_pkg::SQ_W)'(y_reg);
    assign sq         = prod[2*vgh_pkg::SQ_W-1 -: vgh_pkg::SQ_W+1];

    // Normalise one bit a cycle, then one squaring round a cycle.
    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        e_next     = e_reg;
        y_next     = y_reg;
        frac_next  = frac_reg;
        k_next     = k_reg;
        unique case (state_reg)
            L_IDLE: begin
                if (start) begin
                    x_next     = x;
                    e_next     = vgh_pkg::EXP_W'(CW - 1);
                    frac_next  = '0;
                    state_next = L_NORM;
                end
            end
            L_NORM: begin
                if (x_reg[CW-1] || (e_reg == '0)) begin
                    y_next     = {1'b1, mant, {(vgh_pkg::SQ_W-1-FB){1'b0}}};
                    k_next     = '0;
                    state_next = L_SQ;
                end else begin
                    x_next = {x_reg[CW-2:0], 1'b0};
                    e_next = e_reg - 1'b1;
                end
            end
            L_SQ: begin
                if (sq[vgh_pkg::SQ_W]) begin
                    y_next    = sq[vgh_pkg::SQ_W:1];
                    frac_next = {frac_reg[FB-2:0], 1'b1};
                end else begin
                    y_next    = sq[vgh_pkg::SQ_W-1:0];
                    frac_next = {frac_reg[FB-2:0], 1'b0};
                end
                k_next = k_reg + 1'b1;
                if (k_reg == vgh_pkg::ROUND_W'(FB - 1)) begin
                    state_next = L_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        e_reg    <= e_next;
        y_reg    <= y_next;
        frac_reg <= frac_next;
        k_reg    <= k_next;
    end

    assign done   = done_reg;
    assign result = {e_reg, frac_reg};

endmodule

/* hdl/vgh_divider.sv */
`timescale 1ns / 1ps

module vgh_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [vgh_pkg::NUM_W-1:0]   num,
    input  logic [vgh_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [vgh_pkg::NUM_W-1:0]   quotient
);

    localparam int NW = vgh_pkg::NUM_W;
    localparam int DW = vgh_pkg::DEN_W;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [vgh_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [NW-1:0]                num_reg, num_next;
    logic [DW-1:0]                den_reg, den_next;
    logic [DW:0]                  rem_reg, rem_next;
    logic [DW:0]                  rem_sh;
    logic [DW:0]                  rem_sub;
    logic                         fits;

    // One restoring step: shift in the next numerator bit and try the subtract.
    assign rem_sh  = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                step_next = '0;
                num_next  = num;
                den_next  = den;
                rem_next  = '0;
            end
        end else begin
            rem_next  = fits ? rem_sub : rem_sh;
            num_next  = {num_reg[NW-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == vgh_pkg::STEP_W'(NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand registers; the numerator register collects the quotient.
    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

/* hdl/vgh_datapath.sv */
`timescale 1ns / 1ps

module vgh_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              kind,
    input  vgh_pkg::in_t      s_data,
    input  vgh_pkg::cmd_t     cmd,
    output vgh_pkg::status_t  status,
    output logic              m_valid,
    input  logic              m_ready,
    output vgh_pkg::out_t     m_data
);

    localparam int CW = vgh_pkg::COUNT_WIDTH;
    localparam int AW = vgh_pkg::BIN_ADDR_W;
    localparam int BW = vgh_pkg::BYTE_W;
    localparam int SW = vgh_pkg::SCALE_W;

    logic [CW-1:0]            mem [vgh_pkg::BIN_COUNT];
    vgh_pkg::in_t             item_reg;
    logic [CW-1:0]            rd_data_reg;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            max_reg, max_next;
    logic [AW-1:0]            clr_addr_reg, clr_addr_next;
    logic [vgh_pkg::LOG_W-1:0] lm_reg;
    logic [SW-1:0]            scaled_reg;
    logic                     m_valid_reg, m_valid_next;
    vgh_pkg::out_t            m_data_reg;
    logic [AW-1:0]            addr;
    logic [AW-1:0]            wr_addr;
    logic [CW-1:0]            wr_data;
    logic                     mem_we;
    logic [CW-1:0]            inc;
    logic                     log_done;
    logic [vgh_pkg::LOG_W-1:0] log_result;
    logic [CW-1:0]            log_x;
    logic                     div_done;
    logic [vgh_pkg::NUM_W-1:0] div_q;
    logic [vgh_pkg::NUM_W-1:0] div_num;
    logic [vgh_pkg::DEN_W-1:0] div_den;
    logic [vgh_pkg::DEN_W-1:0] div_op;
    logic [SW-1:0]            q_clamped;

    // Bin address of the held item under the current kind.
    always_comb begin
        if (item_reg.mode == vgh_pkg::MODE_ACCUMULATE) begin
            addr = (kind == vgh_pkg::KIND_VALUE)
                 ? {{(AW-BW){1'b0}}, item_reg.voxel_value}
                 : {item_reg.gradient_value, item_reg.voxel_value};
        end else begin
            addr = (kind == vgh_pkg::KIND_VALUE)
                 ? {{(AW-BW){1'b0}}, item_reg.bin_index[BW-1:0]}
                 : item_reg.bin_index;
        end
    end

    // Saturating increment of the bin just read.
    assign inc     = (&rd_data_reg) ? rd_data_reg : rd_data_reg + 1'b1;
    assign mem_we  = cmd.clr_wr | cmd.acc_wr;
    assign wr_addr = cmd.clr_wr ? clr_addr_reg : addr;
    assign wr_data = cmd.clr_wr ? '0 : inc;

    // Bin memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= mem[addr];
        end
    end

    // Running maximum and clear sweep address.
    always_comb begin
        max_next      = max_reg;
        clr_addr_next = clr_addr_reg;
        if (cmd.clr_start) begin
            max_next      = '0;
            clr_addr_next = '0;
        end else if (cmd.clr_wr) begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end else if (cmd.acc_wr && (inc > max_reg)) begin
            max_next = inc;
        end
    end

    // Output register: loaded by the controller, emptied by the consumer.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg      <= '0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            max_reg      <= max_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Log and divide operands: 255*x is formed as x*256 - x.
    assign log_x   = cmd.log_sel_max ? max_reg : cnt_reg;
    assign div_op  = cmd.div_sel_log ? vgh_pkg::DEN_W'(log_result)
                                     : vgh_pkg::DEN_W'(cnt_reg);
    assign div_num = {div_op, {SW{1'b0}}} - vgh_pkg::NUM_W'(div_op);
    assign div_den = cmd.div_sel_log ? vgh_pkg::DEN_W'(lm_reg)
                                     : vgh_pkg::DEN_W'(max_reg);
    assign q_clamped = (|div_q[vgh_pkg::NUM_W-1:SW]) ? {SW{1'b1}} : div_q[SW-1:0];

    vgh_log_unit u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.log_start),
        .x       (log_x),
        .done    (log_done),
        .result  (log_result)
    );

    vgh_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // Item, operand and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_data;
        end
        if (cmd.cnt_load) begin
            cnt_reg <= rd_data_reg;
        end
        if (cmd.lm_load) begin
            lm_reg <= log_result;
        end
        if (cmd.scale_zero) begin
            scaled_reg <= '0;
        end else if (cmd.scale_load) begin
            scaled_reg <= q_clamped;
        end
        if (cmd.out_load) begin
            m_data_reg.bin_count    <= cnt_reg;
            m_data_reg.scaled_value <= scaled_reg;
        end
    end

    assign status.cnt_zero = (cnt_reg == '0);
    assign status.max_zero = (max_reg == '0);
    assign status.max_le1  = (max_reg[CW-1:1] == '0);
    assign status.lm_zero  = (lm_reg == '0);
    assign status.log_done = log_done;
    assign status.div_done = div_done;
    assign status.clr_last = (&clr_addr_reg);
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hdl/vgh_ctrl.sv */
`timescale 1ns / 1ps

module vgh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic              kind,
    input  vgh_pkg::status_t  status,
    output vgh_pkg::cmd_t     cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLEAR  = 4'd1;
    localparam logic [3:0] ST_ACC_RD = 4'd2;
    localparam logic [3:0] ST_ACC_WR = 4'd3;
    localparam logic [3:0] ST_RD_RD  = 4'd4;
    localparam logic [3:0] ST_RD_LAT = 4'd5;
    localparam logic [3:0] ST_RD_DEC = 4'd6;
    localparam logic [3:0] ST_LOG_M  = 4'd7;
    localparam logic [3:0] ST_LOG_C  = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Sequencer: one item at a time, each through its own chain of states.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.item_load = 1'b1;
                    priority case (s_mode)
                        vgh_pkg::MODE_ACCUMULATE: state_next = ST_ACC_RD;
                        vgh_pkg::MODE_READ:       state_next = ST_RD_RD;
                        vgh_pkg::MODE_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:                  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR: begin
                cmd.acc_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_RD_LAT;
            end
            ST_RD_LAT: begin
                cmd.cnt_load = 1'b1;
                state_next   = ST_RD_DEC;
            end
            ST_RD_DEC: begin
                if (kind == vgh_pkg::KIND_VALUE) begin
                    if (status.max_zero) begin
                        cmd.scale_zero = 1'b1;
                        state_next     = ST_OUT;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end else if (status.cnt_zero || status.max_le1) begin
                    cmd.scale_zero = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    cmd.log_start   = 1'b1;
                    cmd.log_sel_max = 1'b1;
                    state_next      = ST_LOG_M;
                end
            end
            ST_LOG_M: begin
                if (status.log_done) begin
                    cmd.lm_load   = 1'b1;
                    cmd.log_start = 1'b1;
                    state_next    = ST_LOG_C;
                end
            end
            ST_LOG_C: begin
                if (status.log_done) begin
                    if (status.lm_zero) begin
                        cmd.scale_zero = 1'b1;
                        state_next     = ST_OUT;
                    end else begin
                        cmd.div_start   = 1'b1;
                        cmd.div_sel_log = 1'b1;
                        state_next      = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_sel_log = (kind == vgh_pkg::KIND_JOINT);
                if (status.div_done) begin
                    cmd.scale_load = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The bins are swept clear after reset before the first item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // A result is only loaded when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over an unread result");

    // The clear sweep ends on the last bin and returns to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && status.clr_last) |=> (state_reg == ST_IDLE))
        else $error("clear sweep did not finish");

    // An accumulate transaction passes through its memory read state, then writes back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == vgh_pkg::MODE_ACCUMULATE) |-> ##2 cmd.acc_wr)
        else $error("accumulate write-back missing");

    // The log unit is never started while a division is under way.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !cmd.log_start)
        else $error("log unit started during division");
`endif

endmodule
